// ===== rtl/stt_pkg.sv =====
package stt_pkg;

	localparam int FRAC_BITS = 24;
	localparam int COUNT_W   = 16;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	localparam longint ONE_RAW = longint'(1) << FRAC_BITS;
	localparam longint K98_RAW = ONE_RAW * 98 / 10;

	localparam logic signed [31:0] K_05 = 32'(ONE_RAW * 5 / 10);
	localparam logic signed [31:0] K_02 = 32'(ONE_RAW * 2 / 10);
	localparam logic signed [31:0] K_08 = 32'(ONE_RAW * 8 / 10);
	localparam logic signed [31:0] K_09 = 32'(ONE_RAW * 9 / 10);
	localparam logic signed [31:0] K_01 = 32'(ONE_RAW * 1 / 10);
	localparam logic signed [31:0] K_10 = 32'(ONE_RAW);
	localparam logic signed [31:0] K_98 = (K98_RAW > longint'(2147483647)) ? Q_MAX : 32'(K98_RAW);
	localparam logic signed [31:0] K_13 = 32'(ONE_RAW * 33333333 / 100000000);
	localparam logic signed [31:0] K_23 = 32'(ONE_RAW * 66666667 / 100000000);

	localparam logic [2:0] REG_BASE   = 3'd0;
	localparam logic [2:0] REG_EXT_UP = 3'd1;
	localparam logic [2:0] REG_EXT_DN = 3'd2;
	localparam logic [2:0] REG_P2M    = 3'd3;
	localparam logic [2:0] REG_F2T    = 3'd4;
	localparam logic [2:0] REG_PERIOD = 3'd5;
	localparam logic [2:0] REG_NOMASS = 3'd6;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
		return s[31:0];
	endfunction

endpackage

// ===== rtl/stt_mul.sv =====
module stt_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] res
);
	import stt_pkg::*;

	logic signed [63:0] prod_q;
	logic signed [63:0] shifted;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	always_comb begin
		shifted = prod_q >>> FRAC_BITS;
		if (shifted > 64'sd2147483647) res = Q_MAX;
		else if (shifted < -64'sd2147483648) res = Q_MIN;
		else res = shifted[31:0];
	end

endmodule

// ===== rtl/stt_div.sv =====
module stt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  stt_pkg::div_req_t req,
	output stt_pkg::div_rsp_t rsp
);
	import stt_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t            state_q;
	logic [31:0]        rem_q;
	logic [31:0]        low_q;
	logic [31:0]        quot_q;
	logic [31:0]        mb_q;
	logic [4:0]         cnt_q;
	logic               neg_q;
	logic               done_q;
	logic signed [31:0] q_q;

	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] nwide;
	logic [32:0] trial;
	logic        qbit;

	always_comb begin
		ma    = req.num[31] ? 32'(~req.num + 32'd1) : 32'(req.num);
		mb    = req.den[31] ? 32'(~req.den + 32'd1) : 32'(req.den);
		nwide = {32'd0, ma} << FRAC_BITS;
		trial = {rem_q, low_q[31]};
		qbit  = trial >= {1'b0, mb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						neg_q <= req.num[31] ^ req.den[31];
						mb_q  <= mb;
						if (req.den == 32'sd0) begin
							q_q    <= req.num[31] ? Q_MIN : Q_MAX;
							done_q <= 1'b1;
						end else if (nwide[63:32] >= mb) begin
							q_q    <= (req.num[31] ^ req.den[31]) ? Q_MIN : Q_MAX;
							done_q <= 1'b1;
						end else begin
							rem_q   <= nwide[63:32];
							low_q   <= nwide[31:0];
							quot_q  <= 32'd0;
							cnt_q   <= 5'd0;
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					rem_q  <= qbit ? 32'(trial - {1'b0, mb_q}) : trial[31:0];
					quot_q <= {quot_q[30:0], qbit};
					low_q  <= {low_q[30:0], 1'b0};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= D_FIN;
				end
				D_FIN: begin
					if (neg_q) q_q <= (quot_q > 32'h80000000) ? Q_MIN : 32'(~quot_q + 32'd1);
					else q_q <= quot_q[31] ? Q_MAX : quot_q;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.busy = state_q != D_IDLE;
	assign rsp.done = done_q;
	assign rsp.quot = q_q;

endmodule

// ===== rtl/stroke_tracker_torque_reference.sv =====
// Stroke tracker and torque reference.
// Input stream s_*: one word per position sample (position and direction bit).
// Output stream m_*: one word per sample with torque reference, segment flag,
// stroke fraction, stroke and shake counts, filtered velocity and acceleration,
// and peak speed.
// APB port: seven registers at byte addresses 0..24; write only while idle.
// Each sample runs through a sequencer that shares one registered 32x32
// multiplier and one serial divider. A zero divisor or an overflowing result
// saturates the quotient without the serial steps. A sample needs two to five
// quotients, and s_tready stays low from accept until the result of that
// sample is loaded into the output register.
// The result sits in an output register; the next sample is accepted while it
// waits. If the receiver stalls, the sequencer holds at its last step until the
// register frees, and s_tready stays low.
// Reset clears all stroke and motion state and loads register defaults
// (sample_period 16777, no_mass_mode 1).
module stroke_tracker_torque_reference (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // position[31:0], direction[32], zero pad
	output logic         m_tvalid,
	input  logic         m_tready,
	// torque_ref[31:0], lifting[32], stroke_fraction[64:33], strokes_seen[80:65],
	// shakes_seen[96:81], velocity_filtered[128:97], accel_filtered[160:129],
	// peak_speed[191:161]
	output logic [191:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import stt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_STROKE, S_G1, S_G2, S_G3, S_G4, S_G5, S_FRAC, S_FRACW,
		S_PM, S_VEL, S_VELW, S_VF1, S_VF2, S_VF3, S_ACCW, S_AF1, S_AF2, S_AF3,
		S_AV1, S_AV2, S_T0, S_T1, S_T1W, S_T2, S_T3W, S_T4, S_T4B, S_T5,
		S_TFIN, S_OUT
	} state_t;

	state_t state_q;

	logic signed [31:0] base_q, ext_up_q, ext_dn_q, p2m_q, f2t_q, period_q;
	logic               nomass_q;

	logic signed [31:0] pos_q;
	logic               dir_q;
	logic               pdir_q, seg_q, pseg_q, upd_q;
	logic [COUNT_W-1:0] stroke_cnt_q, shake_cnt_q;
	logic signed [31:0] start_q, stop_q, gstart_q, gstop_q, dist_q, frac_q;
	logic signed [31:0] hpos_q, hvel_q, hacc_q, vflt_q, aflt_q;
	logic [30:0]        peak_q;
	logic signed [31:0] pm_q, vel_q, acc_q, avg_q, inertia_q, tmp_q, tmp2_q, tq_q;
	logic [191:0]       out_q;

	logic signed [31:0] mul_a, mul_b, mres;
	div_req_t           dreq;
	div_rsp_t           drsp;

	stt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .res(mres));
	stt_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [2:0] reg_idx;
	logic       cfg_wr;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_idx)
			REG_BASE:   prdata = base_q;
			REG_EXT_UP: prdata = ext_up_q;
			REG_EXT_DN: prdata = ext_dn_q;
			REG_P2M:    prdata = p2m_q;
			REG_F2T:    prdata = f2t_q;
			REG_PERIOD: prdata = period_q;
			REG_NOMASS: prdata = {31'd0, nomass_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			ext_up_q <= '0;
			ext_dn_q <= '0;
			p2m_q    <= '0;
			f2t_q    <= '0;
			period_q <= 32'sd16777;
			nomass_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BASE:   base_q   <= pwdata;
				REG_EXT_UP: ext_up_q <= pwdata;
				REG_EXT_DN: ext_dn_q <= pwdata;
				REG_P2M:    p2m_q    <= pwdata;
				REG_F2T:    f2t_q    <= pwdata;
				REG_PERIOD: period_q <= pwdata;
				REG_NOMASS: nomass_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// stroke decision for the current sample
	logic               none_yet, dchg, schg, seg_n;
	logic signed [31:0] start0, stop0, gs0, gp0, start_n, stop_n;
	logic               seg0, pseg0;
	logic [COUNT_W-1:0] shake0, cnt_n, shake_n;
	logic               cnt_ge2;
	localparam logic [COUNT_W-1:0] CNT_MAX = '1;
	localparam logic [COUNT_W-1:0] CNT_ONE = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] CNT_TWO = COUNT_W'(2);

	always_comb begin
		none_yet = stroke_cnt_q == '0;
		cnt_ge2  = stroke_cnt_q >= CNT_TWO;
		start0   = none_yet ? 32'sd0 : start_q;
		stop0    = none_yet ? 32'sd0 : stop_q;
		gs0      = none_yet ? 32'sd0 : gstart_q;
		gp0      = none_yet ? 32'sd0 : gstop_q;
		seg0     = none_yet ? 1'b0 : seg_q;
		pseg0    = none_yet ? 1'b0 : pseg_q;
		shake0   = none_yet ? '0 : shake_cnt_q;
		dchg     = dir_q != pdir_q;
		seg_n    = seg0;
		start_n  = start0;
		stop_n   = stop0;
		if (!seg0) begin
			if (dchg && dir_q && ((none_yet && pos_q > K_05) || (cnt_ge2 && pos_q > gp0))) begin
				stop_n = pos_q;
				seg_n  = 1'b1;
			end
		end else begin
			if (dchg && !dir_q && ((stroke_cnt_q == CNT_ONE && pos_q < sub_sat(stop0, K_02))
					|| (cnt_ge2 && pos_q < gs0))) begin
				start_n = pos_q;
				seg_n   = 1'b0;
			end
		end
		schg      = seg_n != pseg0;
		cnt_n     = (dchg && schg && stroke_cnt_q != CNT_MAX) ? stroke_cnt_q + CNT_ONE
			: stroke_cnt_q;
		shake_n   = (dchg && !schg && pos_q > gs0 && pos_q < gp0 && shake0 != CNT_MAX)
			? shake0 + CNT_ONE : shake0;
	end

	// shared unit operand select
	logic signed [31:0] extra, vabs;
	always_comb begin
		extra = seg_q ? ext_dn_q : ext_up_q;
		vabs  = drsp.quot[31] ? ((drsp.quot == Q_MIN) ? Q_MAX : -drsp.quot) : drsp.quot;
		mul_a = '0;
		mul_b = '0;
		dreq  = '0;
		unique case (state_q)
			S_G1: begin mul_a = start_q; mul_b = K_08; end
			S_G2: begin mul_a = start_q; mul_b = K_02; end
			S_G3: begin mul_a = stop_q;  mul_b = K_02; end
			S_G4: begin mul_a = stop_q;  mul_b = K_08; end
			S_FRAC: begin
				dreq.start = cnt_ge2;
				dreq.num   = sub_sat(pos_q, start_q);
				dreq.den   = dist_q;
			end
			S_PM: begin mul_a = pos_q; mul_b = p2m_q; end
			S_VEL: begin
				dreq.start = 1'b1;
				dreq.num   = sub_sat(hpos_q, mres);
				dreq.den   = period_q;
			end
			S_VF1: begin mul_a = vflt_q; mul_b = K_09; end
			S_VF2: begin mul_a = vel_q;  mul_b = K_01; end
			S_VF3: begin
				dreq.start = 1'b1;
				dreq.num   = sub_sat(vel_q, hvel_q);
				dreq.den   = period_q;
			end
			S_AF1: begin mul_a = aflt_q; mul_b = K_09; end
			S_AF2: begin mul_a = acc_q;  mul_b = K_01; end
			S_AF3: begin mul_a = hacc_q; mul_b = K_13; end
			S_AV1: begin mul_a = acc_q;  mul_b = K_23; end
			S_T0: begin
				mul_a = base_q;
				mul_b = cnt_ge2 ? avg_q : f2t_q;
			end
			S_T1: begin
				dreq.start = !nomass_q;
				dreq.num   = mres;
				dreq.den   = K_98;
			end
			S_T2: begin
				dreq.start = (frac_q >= K_09) && (frac_q < K_10);
				dreq.num   = sub_sat(frac_q, K_09);
				dreq.den   = K_01;
			end
			S_T4: begin mul_a = extra; mul_b = tmp2_q; end
			S_T5: begin mul_a = sub_sat(tmp_q, inertia_q); mul_b = f2t_q; end
			default: ;
		endcase
	end

	assign s_tready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_tvalid     <= 1'b0;
			pdir_q       <= 1'b0;
			seg_q        <= 1'b0;
			pseg_q       <= 1'b0;
			upd_q        <= 1'b0;
			stroke_cnt_q <= '0;
			shake_cnt_q  <= '0;
			start_q      <= '0;
			stop_q       <= '0;
			gstart_q     <= '0;
			gstop_q      <= '0;
			dist_q       <= '0;
			frac_q       <= '0;
			hpos_q       <= '0;
			hvel_q       <= '0;
			hacc_q       <= '0;
			vflt_q       <= '0;
			aflt_q       <= '0;
			peak_q       <= '0;
		end else begin
			if (state_q == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pos_q   <= s_tdata[31:0];
						dir_q   <= s_tdata[32];
						state_q <= S_STROKE;
					end
				end
				S_STROKE: begin
					pdir_q       <= dir_q;
					seg_q        <= seg_n;
					pseg_q       <= seg_n;
					start_q      <= start_n;
					stop_q       <= stop_n;
					gstart_q     <= gs0;
					gstop_q      <= gp0;
					stroke_cnt_q <= cnt_n;
					shake_cnt_q  <= shake_n;
					upd_q        <= dchg && schg;
					state_q      <= (dchg && schg) ? S_G1 : S_FRAC;
				end
				S_G1: state_q <= S_G2;
				S_G2: begin tmp_q <= mres; state_q <= S_G3; end
				S_G3: begin tmp2_q <= mres; state_q <= S_G4; end
				S_G4: begin tmp_q <= add_sat(tmp_q, mres); state_q <= S_G5; end
				S_G5: begin
					if (upd_q) begin
						gstart_q <= tmp_q;
						gstop_q  <= add_sat(tmp2_q, mres);
						if (cnt_ge2) dist_q <= sub_sat(stop_q, start_q);
					end
					state_q <= S_FRAC;
				end
				S_FRAC: state_q <= cnt_ge2 ? S_FRACW : S_PM;
				S_FRACW: if (drsp.done) begin frac_q <= drsp.quot; state_q <= S_PM; end
				S_PM: state_q <= S_VEL;
				S_VEL: begin pm_q <= mres; state_q <= S_VELW; end
				S_VELW: begin
					if (drsp.done) begin
						vel_q <= drsp.quot;
						if (vabs > $signed({1'b0, peak_q})) peak_q <= vabs[30:0];
						state_q <= S_VF1;
					end
				end
				S_VF1: state_q <= S_VF2;
				S_VF2: begin tmp_q <= mres; state_q <= S_VF3; end
				S_VF3: begin vflt_q <= add_sat(tmp_q, mres); state_q <= S_ACCW; end
				S_ACCW: if (drsp.done) begin acc_q <= drsp.quot; state_q <= S_AF1; end
				S_AF1: state_q <= S_AF2;
				S_AF2: begin tmp_q <= mres; state_q <= S_AF3; end
				S_AF3: begin aflt_q <= add_sat(tmp_q, mres); state_q <= S_AV1; end
				S_AV1: begin tmp_q <= mres; state_q <= S_AV2; end
				S_AV2: begin
					avg_q   <= add_sat(tmp_q, mres);
					hpos_q  <= pm_q;
					hvel_q  <= vel_q;
					hacc_q  <= acc_q;
					state_q <= S_T0;
				end
				S_T0: state_q <= cnt_ge2 ? S_T1 : S_TFIN;
				S_T1: begin
					if (nomass_q) begin
						inertia_q <= '0;
						state_q   <= S_T2;
					end else begin
						state_q <= S_T1W;
					end
				end
				S_T1W: if (drsp.done) begin inertia_q <= drsp.quot; state_q <= S_T2; end
				S_T2: begin
					priority if (frac_q < K_09) begin
						tmp_q   <= add_sat(base_q, extra);
						state_q <= S_T5;
					end else if (frac_q < K_10) begin
						state_q <= S_T3W;
					end else begin
						tmp_q   <= base_q;
						state_q <= S_T5;
					end
				end
				S_T3W: if (drsp.done) begin tmp2_q <= sub_sat(K_10, drsp.quot); state_q <= S_T4; end
				S_T4: state_q <= S_T4B;
				S_T4B: begin tmp_q <= add_sat(base_q, mres); state_q <= S_T5; end
				S_T5: state_q <= S_TFIN;
				S_TFIN: begin tq_q <= mres; state_q <= S_OUT; end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						out_q <= {peak_q, aflt_q, vflt_q, 16'(shake_cnt_q), 16'(stroke_cnt_q),
							frac_q, seg_q, tq_q};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tdata = out_q;

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !drsp.busy) else $error("divider started while busy");
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !drsp.busy) else $error("ready with divide in flight");
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= $past(peak_q)) else $error("peak speed decreased");
	a_strokes_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		stroke_cnt_q >= $past(stroke_cnt_q)) else $error("stroke count decreased");

endmodule

// ===== tb/torque_ref_checker.sv =====
module torque_ref_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [39:0]  s_tdata,  // position[31:0], direction[32], zero pad
	input  logic         m_tvalid,
	input  logic         m_tready,
	// torque_ref[31:0], lifting[32], stroke_fraction[64:33], strokes_seen[80:65],
	// shakes_seen[96:81], velocity_filtered[128:97], accel_filtered[160:129],
	// peak_speed[191:161]
	input  logic [191:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output int           errors,
	output int           pending
);
	import stt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] torque;
		logic               lifting;
		logic signed [31:0] fraction;
		logic [15:0]        strokes;
		logic [15:0]        shakes;
		logic signed [31:0] vel_flt;
		logic signed [31:0] acc_flt;
		logic [30:0]        peak;
	} sample_out_t;

	sample_out_t sample_q[$];

	longint r_base, r_up, r_dn, r_p2m, r_f2t, r_period;
	logic   r_nomass;

	logic   last_dir, lifting, last_lifting;
	longint strokes, shakes;
	longint seg_start, seg_stop, gate_lo, gate_hi, travel, frac;
	longint last_pos_m, last_vel, last_acc, vel_flt, acc_flt, peak;

	function automatic longint sat(input longint v);
		if (v > longint'(Q_MAX)) return longint'(Q_MAX);
		if (v < longint'(Q_MIN)) return longint'(Q_MIN);
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return sat((a * b) >>> FRAC_BITS);
	endfunction

	function automatic longint qdiv(input longint a, input longint b);
		if (b == 0) return (a >= 0) ? longint'(Q_MAX) : longint'(Q_MIN);
		return sat((a <<< FRAC_BITS) / b);
	endfunction

	function automatic longint bump(input longint c);
		longint lim;
		lim = (longint'(1) << COUNT_W) - 1;
		return (c < lim) ? c + 1 : lim;
	endfunction

	task automatic reset_state();
		r_base = 0; r_up = 0; r_dn = 0; r_p2m = 0; r_f2t = 0;
		r_period = 16777; r_nomass = 1;
		last_dir = 0; lifting = 0; last_lifting = 0;
		strokes = 0; shakes = 0;
		seg_start = 0; seg_stop = 0; gate_lo = 0; gate_hi = 0; travel = 0; frac = 0;
		last_pos_m = 0; last_vel = 0; last_acc = 0; vel_flt = 0; acc_flt = 0; peak = 0;
	endtask

	task automatic predict_sample(input longint pos, input logic dir, output sample_out_t r);
		logic   turned, seg_moved;
		longint pm, vel, av, acc, avg, inertia, extra, f, t, tq;

		if (strokes == 0) begin
			seg_start = 0; seg_stop = 0; gate_lo = 0; gate_hi = 0;
			lifting = 0; last_lifting = 0; shakes = 0;
		end
		turned = dir != last_dir;
		last_dir = dir;
		if (!lifting) begin
			if (turned && dir && ((strokes == 0 && pos > longint'(K_05)) ||
					(strokes >= 2 && pos > gate_hi))) begin
				seg_stop = pos;
				lifting = 1;
			end
		end else begin
			if (turned && !dir && ((strokes == 1 && pos < sat(seg_stop - longint'(K_02))) ||
					(strokes >= 2 && pos < gate_lo))) begin
				seg_start = pos;
				lifting = 0;
			end
		end
		seg_moved = lifting != last_lifting;
		last_lifting = lifting;
		if (turned) begin
			if (seg_moved) begin
				strokes = bump(strokes);
				gate_lo = sat(qmul(seg_start, K_08) + qmul(seg_stop, K_02));
				gate_hi = sat(qmul(seg_start, K_02) + qmul(seg_stop, K_08));
				if (strokes >= 2) travel = sat(seg_stop - seg_start);
			end else if (pos > gate_lo && pos < gate_hi) begin
				shakes = bump(shakes);
			end
		end
		if (strokes >= 2) frac = qdiv(sat(pos - seg_start), travel);

		pm = qmul(pos, r_p2m);
		vel = qdiv(sat(last_pos_m - pm), r_period);
		av = (vel < 0) ? sat(-vel) : vel;
		if (av > peak) peak = av;
		vel_flt = sat(qmul(vel_flt, K_09) + qmul(vel, K_01));
		acc = qdiv(sat(vel - last_vel), r_period);
		acc_flt = sat(qmul(acc_flt, K_09) + qmul(acc, K_01));
		avg = sat(qmul(last_acc, K_13) + qmul(acc, K_23));
		last_pos_m = pm;
		last_vel = vel;
		last_acc = acc;

		if (strokes < 2) begin
			tq = qmul(r_base, r_f2t);
		end else begin
			inertia = r_nomass ? 0 : qdiv(qmul(r_base, avg), K_98);
			extra = lifting ? r_dn : r_up;
			if (frac < longint'(K_09)) begin
				f = sat(r_base + extra);
			end else if (frac < longint'(K_10)) begin
				t = sat(longint'(K_10) - qdiv(sat(frac - longint'(K_09)), K_01));
				f = sat(r_base + qmul(extra, t));
			end else begin
				f = r_base;
			end
			tq = qmul(sat(f - inertia), r_f2t);
		end

		r.torque = tq[31:0];
		r.lifting = lifting;
		r.fraction = frac[31:0];
		r.strokes = strokes[15:0];
		r.shakes = shakes[15:0];
		r.vel_flt = vel_flt[31:0];
		r.acc_flt = acc_flt[31:0];
		r.peak = peak[30:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_out_t e, a;
		if (!arst_n) begin
			reset_state();
			sample_q.delete();
			errors <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_BASE:   r_base = longint'($signed(pwdata));
					REG_EXT_UP: r_up = longint'($signed(pwdata));
					REG_EXT_DN: r_dn = longint'($signed(pwdata));
					REG_P2M:    r_p2m = longint'($signed(pwdata));
					REG_F2T:    r_f2t = longint'($signed(pwdata));
					REG_PERIOD: r_period = longint'($signed(pwdata));
					REG_NOMASS: r_nomass = pwdata[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_sample(longint'($signed(s_tdata[31:0])), s_tdata[32], e);
				sample_q.push_back(e);
			end
			if (m_tvalid && m_tready) begin
				a.torque = m_tdata[31:0];
				a.lifting = m_tdata[32];
				a.fraction = m_tdata[64:33];
				a.strokes = m_tdata[80:65];
				a.shakes = m_tdata[96:81];
				a.vel_flt = m_tdata[128:97];
				a.acc_flt = m_tdata[160:129];
				a.peak = m_tdata[191:161];
				if (sample_q.size() == 0) begin
					$error("result word with nothing expected");
					errors <= errors + 1;
				end else begin
					e = sample_q.pop_front();
					if (a != e) errors <= errors + 1;
					if (a.torque != e.torque)
						$error("torque_ref exp %0d got %0d", e.torque, a.torque);
					if (a.lifting != e.lifting)
						$error("lifting exp %0d got %0d", e.lifting, a.lifting);
					if (a.fraction != e.fraction)
						$error("stroke_fraction exp %0d got %0d", e.fraction, a.fraction);
					if (a.strokes != e.strokes)
						$error("strokes_seen exp %0d got %0d", e.strokes, a.strokes);
					if (a.shakes != e.shakes)
						$error("shakes_seen exp %0d got %0d", e.shakes, a.shakes);
					if (a.vel_flt != e.vel_flt)
						$error("velocity_filtered exp %0d got %0d", e.vel_flt, a.vel_flt);
					if (a.acc_flt != e.acc_flt)
						$error("accel_filtered exp %0d got %0d", e.acc_flt, a.acc_flt);
					if (a.peak != e.peak)
						$error("peak_speed exp %0d got %0d", e.peak, a.peak);
				end
			end
		end
	end

	assign pending = sample_q.size();

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
	import stt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 6000;
	localparam int SAMPLES  = 1650;
	localparam longint ONE  = longint'(1) << FRAC_BITS;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;  // position[31:0], direction[32], zero pad
	logic         m_tvalid;
	logic         m_tready;
	// torque_ref[31:0], lifting[32], stroke_fraction[64:33], strokes_seen[80:65],
	// shakes_seen[96:81], velocity_filtered[128:97], accel_filtered[160:129],
	// peak_speed[191:161]
	logic [191:0] m_tdata;
	logic         psel, penable, pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata, prdata;
	logic         pready;
	int           errors, pending, sent;
	int           quiet = 0;
	logic         calm;

	stroke_tracker_torque_reference dut (.*);

	torque_ref_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			n = gap_len();
			if (n > 0) begin
				m_tready = 0;
				repeat (n) @(negedge clk);
			end
			m_tready = 1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
		psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0; penable = 0; pwrite = 0;
	endtask

	task automatic load_regs(input logic [31:0] base, up, dn, p2m, f2t, period,
		input logic nomass);
		reg_write(REG_BASE, base);
		reg_write(REG_EXT_UP, up);
		reg_write(REG_EXT_DN, dn);
		reg_write(REG_P2M, p2m);
		reg_write(REG_F2T, f2t);
		reg_write(REG_PERIOD, period);
		reg_write(REG_NOMASS, {31'd0, nomass});
	endtask

	task automatic send_word(input longint pos, input logic dir);
		int n;
		n = gap_len();
		if (n > 0) begin
			s_tvalid = 0;
			repeat (n) @(negedge clk);
		end
		s_tdata = {7'd0, dir, pos[31:0]};
		s_tvalid = 1;
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (pending != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	// rising legs carry direction 0, falling legs direction 1
	task automatic stroke_leg(input longint from_p, input longint to_p);
		int     steps;
		longint p, step;
		logic   dir;
		steps = $urandom_range(3, 20);
		step = (to_p - from_p) / steps;
		dir = to_p < from_p;
		p = from_p;
		for (int i = 0; i < steps; i++) begin
			p = p + step + $signed($urandom_range(0, 2000)) - 1000;
			if ($urandom_range(0, 99) < 6) begin
				send_word(p, ~dir);
				send_word(p + step / 2, ~dir);
			end
			send_word(p, dir);
		end
		send_word(to_p, dir);
	endtask

	task automatic random_run(input int count);
		longint lo, hi;
		int target;
		target = sent + count;
		while (sent < target) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 6)) send_word(longint'($signed($urandom())),
					1'($urandom_range(0, 1)));
			end else begin
				hi = $urandom_range(0, 2 * ONE) + ONE;
				lo = longint'($urandom_range(0, ONE)) - ONE / 2;
				stroke_leg(lo, hi);
				stroke_leg(hi, lo);
			end
		end
	endtask

	initial begin
		logic [31:0] p2m;
		arst_n = 0; s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		sent = 0; calm = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		load_regs(32'(10 * ONE), 32'(2 * ONE), -32'(3 * ONE), 32'(ONE / 3),
			32'(ONE / 2), 32'd16777, 1'b0);
		send_word(0, 0);
		send_word(longint'(Q_MAX), 1);
		send_word(longint'(Q_MIN), 0);
		send_word(-1, 1);
		send_word(ONE, 0);
		send_word(ONE, 1);
		send_word(ONE / 5, 0);
		send_word(ONE + ONE / 5, 1);
		send_word(ONE * 6 / 10, 0);
		send_word(ONE * 7 / 10, 1);
		send_word(ONE / 10, 0);
		send_word(ONE, 0);
		send_word(ONE + ONE / 10, 0);
		send_word(ONE + ONE / 8, 0);
		send_word(2 * ONE, 0);
		send_word(2 * ONE, 1);
		send_word(0, 1);
		send_word(0, 0);
		send_word(longint'(Q_MIN), 0);
		send_word(longint'(Q_MAX), 0);
		drain();

		for (int ph = 0; sent < SAMPLES; ph++) begin
			calm = (ph % 3) == 2;
			p2m = 32'($urandom_range(ONE / 8, ONE / 2));
			case (ph % 6)
				0: load_regs(32'(20 * ONE), 32'(5 * ONE), 32'(ONE), p2m, 32'(ONE / 3),
					32'd16777, 1'b1);
				1: load_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), 1'($urandom_range(0, 1)));
				2: load_regs(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
				3: load_regs(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
				4: load_regs(32'(5 * ONE), -32'(2 * ONE), 32'(3 * ONE), p2m, 32'(ONE),
					32'd0, 1'b0);
				default: load_regs(-32'(8 * ONE), 32'(ONE), -32'(ONE), p2m, 32'(2 * ONE),
					32'd1, 1'b0);
			endcase
			random_run(200);
			drain();
		end

		if (errors == 0) $display("tb_top: clean");
		else $display("tb_top: errors");
		$finish;
	end

endmodule
